// File: hdl/crssu_pkg.sv
// Shared types, constants and handshake payloads for the cell rate update block.
`timescale 1ns / 1ps

package crssu_pkg;

    localparam int CELL_W     = 16;
    localparam int AREA_W     = 63;
    localparam int FRAC_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Signed Q32.32 value
    typedef logic signed [63:0] q_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
    localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_FACTOR = 1'b0,
        REG_TIME_STEP   = 1'b1
    } cfg_reg_t;

    // Input item
    typedef struct packed {
        logic [CELL_W-1:0] cell_number;
        q_t                cell_rate;
        q_t                stage_in;
        q_t                bed_level;
        q_t                xmom_in;
        q_t                ymom_in;
        logic [AREA_W-1:0] owned_area;
        logic              final_cell;
    } crssu_in_t;

    // Result item
    typedef struct packed {
        logic [CELL_W-1:0] cell_out;
        q_t                stage_out;
        q_t                xmom_out;
        q_t                ymom_out;
        q_t                influx_total;
        logic              run_done;
        logic              overflow_flag;
    } crssu_out_t;

    // Response of the shared multiplier
    typedef struct packed {
        logic done;
        logic sat;
        q_t   value;
    } crssu_mul_rsp_t;

    // Response of the fraction divider
    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } crssu_div_rsp_t;

    // Item sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_TS,
        ST_WAIT_TS,
        ST_MUL_STEP,
        ST_WAIT_STEP,
        ST_DEPTH,
        ST_NEGATE,
        ST_CLAMP,
        ST_DIV,
        ST_WAIT_DIV,
        ST_MUL_X,
        ST_WAIT_X,
        ST_MUL_Y,
        ST_WAIT_Y,
        ST_MUL_AREA,
        ST_WAIT_AREA,
        ST_ACCUM
    } crssu_state_t;

endpackage

// File: hdl/crssu_in_if.sv
// Input item channel: valid/ready handshake carrying one mesh cell.
`timescale 1ns / 1ps

interface crssu_in_if import crssu_pkg::*; ();
    logic      valid;
    logic      ready;
    crssu_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/crssu_out_if.sv
// Result item channel: valid/ready handshake carrying one updated cell.
`timescale 1ns / 1ps

interface crssu_out_if import crssu_pkg::*; ();
    logic       valid;
    logic       ready;
    crssu_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/crssu_qmul.sv
// Iterative signed Q32.32 multiplier: one 32x32 partial product a cycle, rounded and saturated.
`timescale 1ns / 1ps

module crssu_qmul import crssu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  q_t             op_a,
    input  q_t             op_b,
    output crssu_mul_rsp_t rsp
);

    localparam logic [2:0]   LAST_PP    = 3'd3;
    localparam logic [2:0]   LAST_ADD   = 3'd4;
    localparam logic [2:0]   DONE_PHASE = 3'd5;
    // Half an LSB of the result, preloaded so the sum comes out rounded
    localparam logic [127:0] ROUND_INIT = 128'h8000_0000;
    localparam logic [63:0]  MAG_MIN    = 64'h8000_0000_0000_0000;

    logic         busy_reg, busy_next;
    logic [2:0]   phase_reg, phase_next;
    logic         neg_reg;
    logic [63:0]  x_reg;
    logic [63:0]  y_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_pos_reg;
    logic [127:0] acc_reg;

    logic [31:0]  x_sel;
    logic [31:0]  y_sel;
    logic [127:0] pp_shifted;
    logic         hi_over;
    logic [63:0]  mag;

    // Control
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 3'd1;
            if (phase_reg == DONE_PHASE)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    // Pick the operand halves for this partial product
    assign x_sel = phase_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign y_sel = phase_reg[0] ? y_reg[63:32] : y_reg[31:0];

    // Align the registered partial product
    always_comb
    begin
        unique case (pp_pos_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
    end

    // Operands, partial products and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= op_a[63] ^ op_b[63];
            x_reg   <= op_a[63] ? (~op_a + 64'd1) : op_a;
            y_reg   <= op_b[63] ? (~op_b + 64'd1) : op_b;
            acc_reg <= ROUND_INIT;
        end
        else if (busy_reg)
        begin
            if (phase_reg <= LAST_PP)
            begin
                pp_reg     <= x_sel * y_sel;
                pp_pos_reg <= 2'(phase_reg[1] + phase_reg[0]);
            end
            if (phase_reg >= 3'd1 && phase_reg <= LAST_ADD)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    // Saturate the rounded magnitude and apply the sign
    assign hi_over = |acc_reg[127:96];
    assign mag     = acc_reg[95:32];

    always_comb
    begin
        rsp.done  = busy_reg && (phase_reg == DONE_PHASE);
        rsp.sat   = 1'b0;
        rsp.value = q_t'(mag);
        if (neg_reg)
        begin
            if (hi_over || mag > MAG_MIN)
            begin
                rsp.sat   = 1'b1;
                rsp.value = Q_MIN;
            end
            else
            begin
                rsp.value = q_t'(~mag + 64'd1);
            end
        end
        else if (hi_over || mag[63])
        begin
            rsp.sat   = 1'b1;
            rsp.value = Q_MAX;
        end
    end

endmodule

// File: hdl/crssu_qdiv.sv
// Restoring fraction divider: num / den with num < den, one quotient bit a cycle.
`timescale 1ns / 1ps

module crssu_qdiv import crssu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [63:0]    num,
    input  logic [63:0]    den,
    output crssu_div_rsp_t rsp
);

    localparam int         CNT_W     = $clog2(FRAC_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]       rem_reg;
    logic [63:0]       den_reg;
    logic [FRAC_W-1:0] q_reg;

    logic [64:0]       shifted;
    logic [64:0]       diff;
    logic              fits;

    // Control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift, trial subtract, keep the bit
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg && cnt_reg != LAST_STEP)
        begin
            rem_reg <= fits ? diff[63:0] : shifted[63:0];
            q_reg   <= {q_reg[FRAC_W-2:0], fits};
        end
    end

    assign rsp.done     = busy_reg && (cnt_reg == LAST_STEP);
    assign rsp.quotient = q_reg;

endmodule

// File: hdl/cell_rate_source_sink_update.sv
// Top level: item sequencer around the shared multiplier and the fraction divider.
`timescale 1ns / 1ps

// Applies a source or sink rate to one mesh cell per item and keeps the running
// influx total, all in signed Q32.32 with saturation reported in overflow_flag.
// One item is in work at a time; the input is not ready until its result has been
// placed in the output register, which then holds it for the sink while the next
// item is taken. Every product goes through one shared 32x32 multiplier at four
// partial products per product, and the momentum scale comes
// from a divider that yields one quotient bit a cycle. A non-negative rate goes from
// the rate products straight to the influx product; a negative rate first takes the
// depth, negation and clamp, and the momenta are scaled only when water is removed.
// The influx total is cleared after a result marked run_done.
module cell_rate_source_sink_update import crssu_pkg::*;
#(
    parameter int unsigned CELL_COUNT = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    crssu_in_if.sink              in_ch,
    crssu_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Cell count in a width that holds its whole range
    localparam logic [24:0] CELL_COUNT_W = 25'(CELL_COUNT);
    localparam logic [CELL_W-1:0] CELL_COUNT_LO = CELL_COUNT_W[CELL_W-1:0];
    // Rounded-up reciprocal of the cell count, exact for every 16-bit index
    localparam int          MOD_SHIFT   = CELL_W + $clog2(CELL_COUNT);
    localparam logic [63:0] MOD_RECIP   = ((64'd1 << MOD_SHIFT) + 64'(CELL_COUNT) - 64'd1)
                                          / 64'(CELL_COUNT);
    localparam logic [17:0] MOD_RECIP_W = MOD_RECIP[17:0];

    // Saturate a 65-bit signed sum to 64 bits
    function automatic q_t sat_val(input logic [64:0] s);
        q_t r;
        r = q_t'(s[63:0]);
        if (s[64] != s[63])
        begin
            r = s[64] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    crssu_state_t      state_reg, state_next;

    q_t                rate_factor_reg;
    logic [62:0]       time_step_reg;
    q_t                influx_reg, influx_next;
    logic              flag_reg, flag_next;
    logic              out_valid_reg, out_valid_next;
    crssu_out_t        out_reg, out_next;

    q_t                rate_reg, rate_next;
    q_t                stage_reg, stage_next;
    q_t                bed_reg, bed_next;
    q_t                xm_reg, xm_next;
    q_t                ym_reg, ym_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              final_reg, final_next;
    q_t                step_reg, step_next;
    q_t                h_reg, h_next;
    q_t                applied_reg, applied_next;
    q_t                prod_reg, prod_next;
    logic [FRAC_W-1:0] scale_reg, scale_next;

    logic [CELL_W-1:0] mod_src_reg, mod_src_next;
    logic [CELL_W-1:0] mod_q_reg, mod_q_next;
    logic [33:0]       mod_prod;
    logic [CELL_W-1:0] cell_mod;

    logic              accept;
    logic              mul_start;
    q_t                mul_a;
    q_t                mul_b;
    crssu_mul_rsp_t    mul_rsp;
    logic              div_start;
    logic [63:0]       div_num;
    logic [63:0]       div_den;
    crssu_div_rsp_t    div_rsp;

    logic [64:0]       depth_sum;
    logic [64:0]       stage_sum;
    logic [64:0]       influx_sum;
    q_t                clamp_val;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // Shared arithmetic units
    crssu_qmul u_qmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .rsp   (mul_rsp)
    );

    crssu_qdiv u_qdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_factor_reg <= Q_ONE;
            time_step_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RATE_FACTOR: rate_factor_reg <= q_t'(cfg_data);
                REG_TIME_STEP:   time_step_reg   <= cfg_data[62:0];
                default:         ;
            endcase
        end
    end

    // Cell index modulo the cell count: quotient by reciprocal, then remainder
    assign mod_src_next = accept ? in_ch.payload.cell_number : mod_src_reg;
    assign mod_prod     = 34'(mod_src_reg) * 34'(MOD_RECIP_W);
    assign mod_q_next   = CELL_W'(mod_prod >> MOD_SHIFT);
    assign cell_mod     = mod_src_reg - CELL_W'(mod_q_reg * CELL_COUNT_LO);

    // Wide sums used by the sequencer
    assign depth_sum  = {stage_reg[63], stage_reg} - {bed_reg[63], bed_reg};
    assign stage_sum  = {stage_reg[63], stage_reg} + {applied_reg[63], applied_reg};
    assign influx_sum = {influx_reg[63], influx_reg} + {prod_reg[63], prod_reg};
    assign clamp_val  = (step_reg > applied_reg) ? step_reg : applied_reg;

    // Divider operands: water left over the depth plus one LSB
    assign div_num = 64'(applied_reg) + 64'(h_reg);
    assign div_den = 64'(h_reg) + 64'd1;

    // Item sequencer
    always_comb
    begin
        state_next     = state_reg;
        influx_next    = influx_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rate_next      = rate_reg;
        stage_next     = stage_reg;
        bed_next       = bed_reg;
        xm_next        = xm_reg;
        ym_next        = ym_reg;
        area_next      = area_reg;
        final_next     = final_reg;
        step_next      = step_reg;
        h_next         = h_reg;
        applied_next   = applied_reg;
        prod_next      = prod_reg;
        scale_next     = scale_reg;
        mul_start      = 1'b0;
        mul_a          = rate_factor_reg;
        mul_b          = q_t'({1'b0, time_step_reg});
        div_start      = 1'b0;

        // Drop the result once the sink takes it
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    rate_next  = in_ch.payload.cell_rate;
                    stage_next = in_ch.payload.stage_in;
                    bed_next   = in_ch.payload.bed_level;
                    xm_next    = in_ch.payload.xmom_in;
                    ym_next    = in_ch.payload.ymom_in;
                    area_next  = in_ch.payload.owned_area;
                    final_next = in_ch.payload.final_cell;
                    flag_next  = 1'b0;
                    state_next = ST_MUL_TS;
                end
            end

            ST_MUL_TS:
            begin
                mul_start  = 1'b1;
                state_next = ST_WAIT_TS;
            end

            ST_WAIT_TS:
            begin
                if (mul_rsp.done)
                begin
                    step_next  = mul_rsp.value;
                    flag_next  = flag_reg | mul_rsp.sat;
                    state_next = ST_MUL_STEP;
                end
            end

            ST_MUL_STEP:
            begin
                mul_start  = 1'b1;
                mul_a      = step_reg;
                mul_b      = rate_reg;
                state_next = ST_WAIT_STEP;
            end

            ST_WAIT_STEP:
            begin
                if (mul_rsp.done)
                begin
                    step_next    = mul_rsp.value;
                    applied_next = mul_rsp.value;
                    flag_next    = flag_reg | mul_rsp.sat;
                    state_next   = rate_reg[63] ? ST_DEPTH : ST_MUL_AREA;
                end
            end

            // Water depth over the bed
            ST_DEPTH:
            begin
                h_next     = sat_val(depth_sum);
                flag_next  = flag_reg | (depth_sum[64] != depth_sum[63]);
                state_next = ST_NEGATE;
            end

            // Largest removal allowed
            ST_NEGATE:
            begin
                if (h_reg == Q_MIN)
                begin
                    applied_next = Q_MAX;
                    flag_next    = 1'b1;
                end
                else
                begin
                    applied_next = -h_reg;
                end
                state_next = ST_CLAMP;
            end

            ST_CLAMP:
            begin
                applied_next = clamp_val;
                state_next   = clamp_val[63] ? ST_DIV : ST_MUL_AREA;
            end

            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_DIV;
            end

            ST_WAIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    scale_next = div_rsp.quotient;
                    state_next = ST_MUL_X;
                end
            end

            ST_MUL_X:
            begin
                mul_start  = 1'b1;
                mul_a      = xm_reg;
                mul_b      = q_t'({32'b0, scale_reg});
                state_next = ST_WAIT_X;
            end

            ST_WAIT_X:
            begin
                if (mul_rsp.done)
                begin
                    xm_next    = mul_rsp.value;
                    flag_next  = flag_reg | mul_rsp.sat;
                    state_next = ST_MUL_Y;
                end
            end

            ST_MUL_Y:
            begin
                mul_start  = 1'b1;
                mul_a      = ym_reg;
                mul_b      = q_t'({32'b0, scale_reg});
                state_next = ST_WAIT_Y;
            end

            ST_WAIT_Y:
            begin
                if (mul_rsp.done)
                begin
                    ym_next    = mul_rsp.value;
                    flag_next  = flag_reg | mul_rsp.sat;
                    state_next = ST_MUL_AREA;
                end
            end

            // Start the influx product and update the stage meanwhile
            ST_MUL_AREA:
            begin
                mul_start  = 1'b1;
                mul_a      = applied_reg;
                mul_b      = q_t'({1'b0, area_reg});
                stage_next = sat_val(stage_sum);
                flag_next  = flag_reg | (stage_sum[64] != stage_sum[63]);
                state_next = ST_WAIT_AREA;
            end

            ST_WAIT_AREA:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.value;
                    flag_next  = flag_reg | mul_rsp.sat;
                    state_next = ST_ACCUM;
                end
            end

            // Accumulate and hand the item to the output register
            ST_ACCUM:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.cell_out      = cell_mod;
                    out_next.stage_out     = stage_reg;
                    out_next.xmom_out      = xm_reg;
                    out_next.ymom_out      = ym_reg;
                    out_next.influx_total  = sat_val(influx_sum);
                    out_next.run_done      = final_reg;
                    out_next.overflow_flag = flag_reg | (influx_sum[64] != influx_sum[63]);
                    out_valid_next         = 1'b1;
                    influx_next            = final_reg ? '0 : sat_val(influx_sum);
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            influx_reg    <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            influx_reg    <= influx_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        rate_reg    <= rate_next;
        stage_reg   <= stage_next;
        bed_reg     <= bed_next;
        xm_reg      <= xm_next;
        ym_reg      <= ym_next;
        area_reg    <= area_next;
        final_reg   <= final_next;
        step_reg    <= step_next;
        h_reg       <= h_next;
        applied_reg <= applied_next;
        prod_reg    <= prod_next;
        scale_reg   <= scale_next;
        mod_src_reg <= mod_src_next;
        mod_q_reg   <= mod_q_next;
    end

endmodule

// File: tb/sv/cell_rate_checker.sv
// Checker for the cell rate update block: predicts every updated cell and compares results.
`timescale 1ns / 1ps

module cell_rate_checker import crssu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    crssu_in_if                   in_ch,
    crssu_out_if                  out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    cells_pending
);

    // Register copies and running state of the prediction
    q_t          rate_factor_q;
    logic [62:0] step_len_q;
    q_t          influx_acc;
    logic        clip_seen;

    crssu_out_t  expected_cells[$];
    crssu_out_t  oldest_cell;

    // Saturating sum; flag any clipping for the current item
    function automatic q_t sat_add(input q_t a, input q_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            clip_seen = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            clip_seen = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t sat_neg(input q_t a);
        if (a == Q_MIN)
        begin
            clip_seen = 1'b1;
            return Q_MAX;
        end
        return -a;
    endfunction

    // Q32.32 product: exact, magnitude rounded half away from zero, then clipped
    function automatic q_t q_mul(input q_t a, input q_t b);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] prod;
        logic [63:0]  m;
        logic         neg;
        neg   = a[63] ^ b[63];
        mag_a = a[63] ? -a : a;
        mag_b = b[63] ? -b : b;
        prod  = {64'd0, mag_a} * {64'd0, mag_b};
        prod  = prod + 128'h8000_0000;
        if (|prod[127:96])
        begin
            clip_seen = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        m = prod[95:32];
        if (neg)
        begin
            if (m > 64'h8000_0000_0000_0000)
            begin
                clip_seen = 1'b1;
                return Q_MIN;
            end
            return -m;
        end
        if (m[63])
        begin
            clip_seen = 1'b1;
            return Q_MAX;
        end
        return m;
    endfunction

    // Truncated fraction num/den with num below den, one bit per pass
    function automatic logic [63:0] q_frac(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = num;
        quo = '0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Apply the rate to one cell and advance the influx total
    function automatic crssu_out_t update_cell(input crssu_in_t c);
        crssu_out_t  r;
        q_t          step;
        q_t          applied;
        q_t          depth;
        q_t          neg_depth;
        q_t          xm;
        q_t          ym;
        q_t          scale;
        logic [63:0] num;
        logic [63:0] den;
        clip_seen = 1'b0;
        xm        = c.xmom_in;
        ym        = c.ymom_in;
        step      = q_mul(q_mul(rate_factor_q, q_t'({1'b0, step_len_q})), c.cell_rate);
        if (!c.cell_rate[63])
            applied = step;
        else
        begin
            // clamp extraction to the water present
            depth     = sat_sub(c.stage_in, c.bed_level);
            neg_depth = sat_neg(depth);
            applied   = (step > neg_depth) ? step : neg_depth;
            if (applied[63])
            begin
                num   = applied + depth;
                den   = depth + 64'd1;
                scale = q_frac(num, den);
                xm    = q_mul(xm, scale);
                ym    = q_mul(ym, scale);
            end
        end
        r.cell_out      = c.cell_number;
        r.stage_out     = sat_add(c.stage_in, applied);
        r.xmom_out      = xm;
        r.ymom_out      = ym;
        influx_acc      = sat_add(influx_acc, q_mul(applied, q_t'({1'b0, c.owned_area})));
        r.influx_total  = influx_acc;
        r.run_done      = c.final_cell;
        r.overflow_flag = clip_seen;
        if (c.final_cell)
            influx_acc = '0;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want_v,
                                input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    task automatic compare_cell(input crssu_out_t want_c, input crssu_out_t got_c);
        report_field("cell_out", want_c.cell_out, got_c.cell_out);
        report_field("stage_out", want_c.stage_out, got_c.stage_out);
        report_field("xmom_out", want_c.xmom_out, got_c.xmom_out);
        report_field("ymom_out", want_c.ymom_out, got_c.ymom_out);
        report_field("influx_total", want_c.influx_total, got_c.influx_total);
        report_field("run_done", want_c.run_done, got_c.run_done);
        report_field("overflow_flag", want_c.overflow_flag, got_c.overflow_flag);
    endtask

    // Track register writes, check results, then predict newly taken cells
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_factor_q = Q_ONE;
            step_len_q    = '0;
            influx_acc    = '0;
            expected_cells.delete();
            cells_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_RATE_FACTOR)
                    rate_factor_q = cfg_data;
                else if (cfg_index == REG_TIME_STEP)
                    step_len_q = cfg_data[62:0];
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("cell_out: expected no item, got %h", out_ch.payload.cell_out);
                    mismatch_count++;
                end
                else
                begin
                    oldest_cell = expected_cells.pop_front();
                    compare_cell(oldest_cell, out_ch.payload);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_cells.push_back(update_cell(in_ch.payload));
            cells_pending <= expected_cells.size();
        end
    end

endmodule

// File: tb/sv/tb_cell_rate_source_sink_update.sv
// Testbench top: clock, reset, register writes, cell stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_cell_rate_source_sink_update;
    import crssu_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_PAUSE  = 8;
    localparam int END_PAUSE    = 100;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_CELLS  = 276;

    localparam logic [AREA_W-1:0] AREA_ALL  = '1;
    localparam logic [AREA_W-1:0] AREA_HALF = 63'h8000_0000;
    localparam logic [62:0]       STEP_ALL  = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  gaps_on;
    logic                  sink_ready = 1'b0;
    int                    stall_left;
    int                    quiet_cycles;
    int                    mismatch_count;
    int                    cells_pending;

    crssu_in_if  in_ch ();
    crssu_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    cell_rate_source_sink_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cell_rate_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .cells_pending  (cells_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= 1'b1;
    end

    // Abort when neither channel has moved an item for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("cell_rate_source_sink_update: mismatch");
            $finish;
        end
    end

    function automatic q_t small_q();
        q_t v;
        v = {$urandom, $urandom};
        return v >>> $urandom_range(24, 40);
    endfunction

    function automatic q_t wide_q();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return {$urandom, $urandom};
            default: return small_q();
        endcase
    endfunction

    function automatic crssu_in_t make_cell(input logic [CELL_W-1:0] cell_idx, input q_t rate,
                                            input q_t stage, input q_t bed, input q_t xm,
                                            input q_t ym, input logic [AREA_W-1:0] area,
                                            input logic last);
        crssu_in_t c;
        c.cell_number = cell_idx;
        c.cell_rate   = rate;
        c.stage_in    = stage;
        c.bed_level   = bed;
        c.xmom_in     = xm;
        c.ymom_in     = ym;
        c.owned_area  = area;
        c.final_cell  = last;
        return c;
    endfunction

    // Mostly wet cells with extraction, the rest fully random
    function automatic crssu_in_t random_cell();
        crssu_in_t   c;
        q_t          depth;
        logic [63:0] raw;
        raw           = {$urandom, $urandom};
        c.cell_number = CELL_W'($urandom);
        c.owned_area  = AREA_W'(raw >> $urandom_range(0, 40));
        if ($urandom_range(0, 7) == 0)
            c.owned_area = '0;
        c.final_cell = ($urandom_range(0, 15) == 0);
        c.xmom_in    = small_q();
        c.ymom_in    = small_q();
        if ($urandom_range(0, 9) < 7)
        begin
            depth = small_q();
            if (depth < 0)
                depth = -depth;
            c.bed_level = small_q();
            c.stage_in  = c.bed_level + depth;
            c.cell_rate = small_q();
            if ($urandom_range(0, 9) < 6 && c.cell_rate > 0)
                c.cell_rate = -c.cell_rate;
        end
        else
        begin
            c.cell_rate = wide_q();
            c.stage_in  = wide_q();
            c.bed_level = wide_q();
            c.xmom_in   = wide_q();
            c.ymom_in   = wide_q();
        end
        return c;
    endfunction

    // Offer one cell, with an occasional gap first; hold valid until taken
    task automatic send_cell(input crssu_in_t cell_item);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= cell_item;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_cells();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (cells_pending != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic set_config(input q_t factor, input logic [62:0] step_len);
        logic spare_bit;
        spare_bit = $urandom_range(0, 1);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RATE_FACTOR;
        cfg_data  <= factor;
        @(posedge clk);
        cfg_index <= REG_TIME_STEP;
        cfg_data  <= {spare_bit, step_len};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input q_t factor, input logic [62:0] step_len, input logic idle);
        drain_cells();
        set_config(factor, step_len);
        gaps_on <= idle;
        repeat (PHASE_CELLS) send_cell(random_cell());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_RATE_FACTOR;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        gaps_on       = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells at unit factor and unit step
        set_config(Q_ONE, 63'(Q_ONE));
        // plain inflow, then zero rate on the widest area
        send_cell(make_cell(16'd0, 2 * Q_ONE, 5 * Q_ONE, Q_ONE, 3 * Q_ONE, -3 * Q_ONE,
                            63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'hFFFF, '0, 5 * Q_ONE, Q_ONE, 3 * Q_ONE, -3 * Q_ONE,
                            AREA_ALL, 1'b0));
        // partial extraction scales the momenta; heavy extraction empties the cell
        send_cell(make_cell(16'd1, -(Q_ONE / 2), 5 * Q_ONE, Q_ONE, 3 * Q_ONE, -3 * Q_ONE,
                            63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'd2, -10 * Q_ONE, 5 * Q_ONE, Q_ONE, 3 * Q_ONE, -3 * Q_ONE,
                            63'(Q_ONE), 1'b0));
        // dry cell below its bed, then zero depth
        send_cell(make_cell(16'd3, -Q_ONE, Q_ONE, 3 * Q_ONE, Q_ONE, Q_ONE, 63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'd4, -Q_ONE, 2 * Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE,
                            63'(Q_ONE), 1'b0));
        // depth clips high, then clips low and its negation clips too
        send_cell(make_cell(16'd5, -Q_ONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN, '0, 1'b0));
        send_cell(make_cell(16'd6, -Q_ONE, Q_MIN, Q_MAX, Q_ONE, Q_ONE, 63'(Q_ONE), 1'b1));
        // stage clips at the top
        send_cell(make_cell(16'd7, Q_MAX, Q_MAX, '0, '0, '0, '0, 1'b0));
        // half an LSB rounds away from zero both ways; extreme momenta scaled
        send_cell(make_cell(16'd8, q_t'(1), '0, '0, '0, '0, AREA_HALF, 1'b0));
        send_cell(make_cell(16'd9, q_t'(-1), 10 * Q_ONE, '0, Q_MIN, Q_MAX, AREA_HALF, 1'b0));
        // influx product clips, then the running total clips, then it closes
        send_cell(make_cell(16'd10, 256 * Q_ONE, '0, '0, '0, '0, AREA_ALL, 1'b0));
        send_cell(make_cell(16'd11, 256 * Q_ONE, '0, '0, '0, '0, AREA_ALL, 1'b0));
        send_cell(make_cell(16'd12, -Q_ONE, 4 * Q_ONE, '0, '0, '0, AREA_ALL, 1'b1));
        send_cell(make_cell(16'd13, Q_ONE, '0, '0, '0, '0, 63'(Q_ONE), 1'b0));

        // Negative factor: a positive rate removes water without any clamp
        drain_cells();
        set_config(-2 * Q_ONE, 63'(Q_ONE / 2));
        send_cell(make_cell(16'd14, Q_ONE, 5 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, 63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'd15, -Q_ONE, 5 * Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                            63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'd16, Q_MIN, '0, '0, '0, '0, 63'(Q_ONE), 1'b0));
        send_cell(make_cell(16'd17, Q_MAX, '0, '0, '0, '0, 63'(Q_ONE), 1'b1));

        // Random cells over a range of settings, extremes among them
        run_phase(Q_ONE, 63'h0400_0000, 1'b1);
        run_phase(Q_MIN, STEP_ALL, 1'b1);
        run_phase(Q_MAX, '0, 1'b1);
        run_phase('0, 63'({$urandom, $urandom}), 1'b1);
        run_phase(-(Q_ONE + Q_ONE / 2), 63'(Q_ONE / 4), 1'b1);
        run_phase(q_t'({$urandom, $urandom}), 63'({$urandom, $urandom}), 1'b1);
        // closing stretch without idling on either side
        run_phase(Q_ONE, 63'(Q_ONE), 1'b0);

        drain_cells();
        repeat (END_PAUSE) @(posedge clk);
        if (mismatch_count == 0 && cells_pending == 0)
            $display("cell_rate_source_sink_update: match");
        else
            $display("cell_rate_source_sink_update: mismatch");
        $finish;
    end

endmodule
